### hdl/rwcp_pkg.sv
// Shared types and codes for the RIFF/WAVE chunk parser.
// No dependencies; every other file of the parser but rwcp_div imports this package.
`timescale 1ns / 1ps

package rwcp_pkg;

  // Parse status codes as seen on parse_status
  localparam logic [2:0] ST_PARSING  = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_NOT_RIFF = 3'd2;
  localparam logic [2:0] ST_NOT_WAVE = 3'd3;
  localparam logic [2:0] ST_NO_DATA  = 3'd4;

  localparam int unsigned DurW = 42;

  // One parsed byte's result, less the duration, which the back end adds
  typedef struct packed {
    logic        start_div;       // this byte made the status complete
    logic        pcm_valid;
    logic [7:0]  pcm_byte;
    logic [2:0]  parse_status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] avg_byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
  } rwcp_rec_t;

endpackage

### hdl/rwcp_front.sv
// Front end of the parser: byte-wise RIFF/WAVE chunk walk and format capture.
// Depends on rwcp_pkg for the status codes and the result record type.
`timescale 1ns / 1ps

module rwcp_front
  import rwcp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,         // byte transfer this cycle
  input  logic [7:0] data_byte_i,
  input  logic      file_start_i,
  output rwcp_rec_t rec_o
);

  localparam logic [2:0] PH_RIFF = 3'd0;
  localparam logic [2:0] PH_RLEN = 3'd1;
  localparam logic [2:0] PH_WAVE = 3'd2;
  localparam logic [2:0] PH_CID  = 3'd3;
  localparam logic [2:0] PH_CLEN = 3'd4;
  localparam logic [2:0] PH_BODY = 3'd5;
  localparam logic [2:0] PH_PAD  = 3'd6;
  localparam logic [2:0] PH_DONE = 3'd7;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_FACT  = 2'd3;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;

  logic [2:0]  phase_q, phase_d, ph;
  logic [1:0]  biw_q, biw_d, biw;
  logic [31:0] ws_q, ws_d, ws;
  logic [31:0] rend_q, rend_d, rend;
  logic [31:0] wo_q, wo_d, wo;
  logic [31:0] crem_q, crem_d, crem;
  logic [1:0]  kind_q, kind_d, kind;
  logic        pad_q, pad_d, pad;
  logic [7:0]  fmt_q [16];
  logic [7:0]  fmt_d [16];
  logic [31:0] dlen_q, dlen_d, dlen;
  logic [2:0]  st_q, st_d, st;
  logic        valid;
  logic [31:0] idx;
  logic [31:0] wo_inc;

  // Step logic: start from the current state, or the cleared state on file start
  always_comb begin
    ph   = file_start_i ? PH_RIFF    : phase_q;
    biw  = file_start_i ? 2'd0       : biw_q;
    ws   = file_start_i ? 32'd0      : ws_q;
    rend = file_start_i ? 32'd0      : rend_q;
    wo   = file_start_i ? 32'd0      : wo_q;
    crem = file_start_i ? 32'd0      : crem_q;
    kind = file_start_i ? KIND_OTHER : kind_q;
    pad  = file_start_i ? 1'b0       : pad_q;
    dlen = file_start_i ? 32'd0      : dlen_q;
    st   = file_start_i ? ST_PARSING : st_q;
    for (int i = 0; i < 16; i++) begin
      fmt_d[i] = file_start_i ? 8'd0 : fmt_q[i];
    end

    phase_d = ph;
    biw_d   = biw;
    ws_d    = ws;
    rend_d  = rend;
    wo_d    = wo;
    crem_d  = crem;
    kind_d  = kind;
    pad_d   = pad;
    dlen_d  = dlen;
    st_d    = st;
    valid   = 1'b0;
    wo_inc  = wo + 32'd1;
    idx     = ws - crem;

    unique case (ph)
      PH_RIFF, PH_RLEN, PH_WAVE, PH_CID, PH_CLEN: begin
        if (ph == PH_CID || ph == PH_CLEN) begin
          wo_d = wo_inc;
        end
        ws_d  = {data_byte_i, ws[31:8]};
        biw_d = biw + 2'd1;
        if (biw_d == 2'd0) begin
          unique case (ph)
            PH_RIFF: begin
              if (ws_d != TAG_RIFF) begin
                st_d    = ST_NOT_RIFF;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_RLEN;
              end
            end
            PH_RLEN: begin
              rend_d  = ws_d - 32'd4;
              phase_d = PH_WAVE;
            end
            PH_WAVE: begin
              if (ws_d != TAG_WAVE) begin
                st_d    = ST_NOT_WAVE;
                phase_d = PH_DONE;
              end else begin
                wo_d = 32'd0;
                if (rend != 32'd0) begin
                  phase_d = PH_CID;
                end else begin
                  st_d    = ST_NO_DATA;
                  phase_d = PH_DONE;
                end
              end
            end
            PH_CID: begin
              if (ws_d == TAG_FMT) kind_d = KIND_FMT;
              else if (ws_d == TAG_DATA) kind_d = KIND_DATA;
              else if (ws_d == TAG_FACT) kind_d = KIND_FACT;
              else kind_d = KIND_OTHER;
              phase_d = PH_CLEN;
            end
            default: begin
              // chunk length word
              crem_d = ws_d;
              pad_d  = ws_d[0];
              if (kind == KIND_DATA) begin
                dlen_d = ws_d;
              end
              if (ws_d == 32'd0) begin
                // empty chunk, no pad: go on with the walk, or stop with no data past the RIFF end
                if (wo_d < rend) begin
                  phase_d = PH_CID;
                end else begin
                  st_d    = ST_NO_DATA;
                  phase_d = PH_DONE;
                end
              end else begin
                phase_d = PH_BODY;
              end
            end
          endcase
        end
      end
      PH_BODY: begin
        wo_d = wo_inc;
        if (kind == KIND_FMT && idx[31:4] == 28'd0) begin
          fmt_d[idx[3:0]] = data_byte_i;
        end
        valid  = (kind == KIND_DATA);
        crem_d = crem - 32'd1;
        if (crem_d == 32'd0) begin
          if (kind == KIND_DATA) begin
            st_d    = ST_COMPLETE;
            phase_d = PH_DONE;
          end else if (pad) begin
            phase_d = PH_PAD;
          end else if (wo_inc < rend) begin
            phase_d = PH_CID;
            biw_d   = 2'd0;
          end else begin
            st_d    = ST_NO_DATA;
            phase_d = PH_DONE;
          end
        end
      end
      PH_PAD: begin
        wo_d = wo_inc;
        if (wo_inc < rend) begin
          phase_d = PH_CID;
          biw_d   = 2'd0;
        end else begin
          st_d    = ST_NO_DATA;
          phase_d = PH_DONE;
        end
      end
      default: begin
        // final status reached: bytes are ignored until file start
      end
    endcase
  end

  // Result record for this byte
  always_comb begin
    rec_o.start_div       = (st_d == ST_COMPLETE) && (st != ST_COMPLETE);
    rec_o.pcm_valid       = valid;
    rec_o.pcm_byte        = valid ? data_byte_i : 8'd0;
    rec_o.parse_status    = st_d;
    rec_o.format_tag      = {fmt_d[1], fmt_d[0]};
    rec_o.channel_count   = {fmt_d[3], fmt_d[2]};
    rec_o.sample_rate     = {fmt_d[7], fmt_d[6], fmt_d[5], fmt_d[4]};
    rec_o.avg_byte_rate   = {fmt_d[11], fmt_d[10], fmt_d[9], fmt_d[8]};
    rec_o.block_align     = {fmt_d[13], fmt_d[12]};
    rec_o.bits_per_sample = {fmt_d[15], fmt_d[14]};
    rec_o.data_size       = dlen_d;
  end

  // Parse state registers, updated on each byte transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      biw_q   <= 2'd0;
      ws_q    <= 32'd0;
      rend_q  <= 32'd0;
      wo_q    <= 32'd0;
      crem_q  <= 32'd0;
      kind_q  <= KIND_OTHER;
      pad_q   <= 1'b0;
      dlen_q  <= 32'd0;
      st_q    <= ST_PARSING;
      for (int i = 0; i < 16; i++) begin
        fmt_q[i] <= 8'd0;
      end
    end else if (take_i) begin
      phase_q <= phase_d;
      biw_q   <= biw_d;
      ws_q    <= ws_d;
      rend_q  <= rend_d;
      wo_q    <= wo_d;
      crem_q  <= crem_d;
      kind_q  <= kind_d;
      pad_q   <= pad_d;
      dlen_q  <= dlen_d;
      st_q    <= st_d;
      for (int i = 0; i < 16; i++) begin
        fmt_q[i] <= fmt_d[i];
      end
    end
  end

endmodule

### hdl/rwcp_queue.sv
// Small FIFO of parsed result records between front and back ends.
// Depends on rwcp_pkg for the record type.
`timescale 1ns / 1ps

module rwcp_queue
  import rwcp_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rwcp_rec_t push_rec_i,
  input  logic      pop_i,
  output rwcp_rec_t head_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rwcp_rec_t       entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = entry_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### hdl/rwcp_div.sv
// Duration unit: data length times 1000, then a radix-2 restoring divide
// by the average byte rate. Self-contained; no package needed.
`timescale 1ns / 1ps

module rwcp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] length_i,
  input  logic [31:0] rate_i,
  output logic        done_o,
  output logic [41:0] quot_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;

  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam logic [5:0] LAST_STEP = 6'd41;

  logic [1:0]  state_q;
  logic [31:0] len_q;
  logic [31:0] rate_q;
  logic [41:0] quo_q;
  logic [32:0] rem_q;
  logic [5:0]  step_q;
  logic        done_q;
  logic [32:0] rem_sh;
  logic        fits;

  // One quotient bit per step
  assign rem_sh = {rem_q[31:0], quo_q[41]};
  assign fits   = (rem_sh >= {1'b0, rate_q});

  assign done_o = done_q;
  assign quot_o = (rate_q == 32'd0) ? 42'd0 : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= 6'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) state_q <= S_MUL;
        end
        S_MUL: begin
          step_q  <= 6'd0;
          state_q <= S_RUN;
        end
        S_RUN: begin
          step_q <= step_q + 6'd1;
          if (step_q == LAST_STEP) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      len_q  <= length_i;
      rate_q <= rate_i;
    end else if (state_q == S_MUL) begin
      quo_q <= 42'(len_q) * 42'(MS_PER_S);
      rem_q <= 33'd0;
    end else if (state_q == S_RUN) begin
      rem_q <= fits ? rem_sh - {1'b0, rate_q} : rem_sh;
      quo_q <= {quo_q[40:0], fits};
    end
  end

endmodule

### hdl/rwcp_back.sv
// Back end: drains the record queue into the output register and adds the
// duration, computed once per file by rwcp_div. Depends on rwcp_pkg.
`timescale 1ns / 1ps

module rwcp_back
  import rwcp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rwcp_rec_t       head_i,
  input  logic            head_valid_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rwcp_rec_t       out_rec_o,
  output logic [DurW-1:0] out_dur_o
);

  logic            busy_q;
  logic            res_rdy_q;
  rwcp_rec_t       hold_q;
  logic [DurW-1:0] dur_q;
  logic            out_valid_q;
  rwcp_rec_t       out_rec_q;
  logic [DurW-1:0] out_dur_q;
  logic            out_free;
  logic            load_head;
  logic            load_hold;
  logic            start_div;
  logic            div_done;
  logic [DurW-1:0] div_quot;

  assign out_free  = !out_valid_q || out_ready_i;
  assign pop_o     = head_valid_i && !busy_q && (head_i.start_div || out_free);
  assign start_div = pop_o && head_i.start_div;
  assign load_head = pop_o && !head_i.start_div;
  assign load_hold = busy_q && res_rdy_q && out_free;

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;
  assign out_dur_o   = out_dur_q;

  rwcp_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_div),
    .length_i (head_i.data_size),
    .rate_i   (head_i.avg_byte_rate),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  // Completion record waits here while the duration is computed
  always_ff @(posedge clk_i) begin
    if (start_div) begin
      hold_q <= head_i;
    end
  end

  // Control and stored duration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      res_rdy_q <= 1'b0;
      dur_q     <= '0;
    end else begin
      if (start_div) begin
        busy_q <= 1'b1;
      end else if (load_hold) begin
        busy_q    <= 1'b0;
        res_rdy_q <= 1'b0;
      end
      if (div_done) begin
        dur_q     <= div_quot;
        res_rdy_q <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_head || load_hold) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_hold) begin
      out_rec_q <= hold_q;
      out_dur_q <= dur_q;
    end else if (load_head) begin
      out_rec_q <= head_i;
      out_dur_q <= (head_i.parse_status == ST_COMPLETE) ? dur_q : '0;
    end
  end

endmodule

### hdl/riff_wave_chunk_parser.sv
// Top level of the RIFF/WAVE chunk parser: front end, record queue, back end.
// Depends on rwcp_pkg, rwcp_front, rwcp_queue, rwcp_back (with rwcp_div).
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   input   | in_valid_i/in_ready_o, data_byte_i,      | in
//           | file_start_i                             |
//   result  | out_valid_o/out_ready_i, pcm_*, status,  | out
//           | format fields, data_size, duration_ms    |
//
// One byte per cycle while the queue has room: the front end parses each byte
// transfer combinationally and queues its result record, and the record then
// passes through the output register. The byte that completes a data chunk
// waits in the back end after it leaves the queue (one multiply step, 42 divide
// steps, one result latch, one load); later bytes then back up in the
// QueueDepth-entry queue and stall the input once it is full.
// Reset is asynchronous and clears all parse state at once; no clearing pass.
`timescale 1ns / 1ps

module riff_wave_chunk_parser
  import rwcp_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pcm_valid_o,
  output logic [7:0]  pcm_byte_o,
  output logic [2:0]  parse_status_o,
  output logic [15:0] format_tag_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [31:0] avg_byte_rate_o,
  output logic [15:0] block_align_o,
  output logic [15:0] bits_per_sample_o,
  output logic [31:0] data_size_o,
  output logic [41:0] duration_ms_o
);

  logic      take;
  rwcp_rec_t front_rec;
  rwcp_rec_t head_rec;
  rwcp_rec_t out_rec;
  logic      q_empty;
  logic      q_full;
  logic      q_pop;

  assign in_ready_o = !q_full;
  assign take       = in_valid_i && in_ready_o;

  rwcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .rec_o        (front_rec)
  );

  rwcp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (take),
    .push_rec_i (front_rec),
    .pop_i      (q_pop),
    .head_o     (head_rec),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  rwcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_rec),
    .head_valid_i (!q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rec_o    (out_rec),
    .out_dur_o    (duration_ms_o)
  );

  assign pcm_valid_o       = out_rec.pcm_valid;
  assign pcm_byte_o        = out_rec.pcm_byte;
  assign parse_status_o    = out_rec.parse_status;
  assign format_tag_o      = out_rec.format_tag;
  assign channel_count_o   = out_rec.channel_count;
  assign sample_rate_o     = out_rec.sample_rate;
  assign avg_byte_rate_o   = out_rec.avg_byte_rate;
  assign block_align_o     = out_rec.block_align;
  assign bits_per_sample_o = out_rec.bits_per_sample;
  assign data_size_o       = out_rec.data_size;

`ifndef SYNTHESIS
  // A duration is only ever reported with a complete status
  a_dur_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && duration_ms_o != 42'd0 |-> parse_status_o == ST_COMPLETE)
    else $error("duration reported without complete status");

  // Payload bytes only come out while parsing or on the completing byte
  a_pcm_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pcm_valid_o |->
      parse_status_o == ST_PARSING || parse_status_o == ST_COMPLETE)
    else $error("payload byte with a failure status");

  // A byte without payload carries a zero byte
  a_pcm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pcm_valid_o |-> pcm_byte_o == 8'd0)
    else $error("pcm byte not cleared");

  // The queue is never popped while empty
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !q_pop)
    else $error("record queue popped while empty");
`endif

endmodule
